/* rtl/oahm_pkg.sv */
// ----------------------------------------------------------------------------
// oahm_pkg
// Shared constants for the linear probing hash map: defaults, hash, load and operation codes.
// ----------------------------------------------------------------------------
package oahm_pkg;

	localparam int CAPACITY_DEF   = 64;
	localparam int KEY_BITS_DEF   = 32;
	localparam int VALUE_BITS_DEF = 32;

	// multiply-xorshift hash
	localparam logic [31:0] HASH_MULT    = 32'd2654435761;
	localparam int          HASH_SHIFT_A = 15;
	localparam int          HASH_SHIFT_B = 13;

	// load limit: refuse a new key once (count + 1) * LOAD_NUM >= capacity * LOAD_DEN
	localparam int LOAD_NUM = 4;
	localparam int LOAD_DEN = 3;

	localparam logic OP_SET = 1'b0;
	localparam logic OP_GET = 1'b1;

endpackage

/* rtl/oahm_hash.sv */
// ----------------------------------------------------------------------------
// oahm_hash
// Home slot of a key: xorshift, registered multiply, xorshift and mask.
// ----------------------------------------------------------------------------
module oahm_hash import oahm_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF,
	parameter int KEY_BITS = KEY_BITS_DEF,
	parameter int IDX_BITS = $clog2(CAPACITY)
) (
	input  logic                clk,
	input  logic [KEY_BITS-1:0] key,
	output logic [IDX_BITS-1:0] home
);

	// only the low bits of the product reach the slot index
	localparam int PW = IDX_BITS + HASH_SHIFT_B;

	logic [63:0]   key_ext;
	logic [63:0]   mix;
	logic [PW-1:0] prod_s1;
	logic [PW-1:0] fold;

	assign key_ext = 64'(key);
	assign mix     = key_ext ^ (key_ext >> HASH_SHIFT_A);

	always_ff @(posedge clk) begin
		prod_s1 <= mix[PW-1:0] * PW'(HASH_MULT);
	end

	assign fold = prod_s1 ^ (prod_s1 >> HASH_SHIFT_B);
	assign home = fold[IDX_BITS-1:0] & IDX_BITS'(CAPACITY - 1);

endmodule

/* rtl/oahm_slot_ram.sv */
// ----------------------------------------------------------------------------
// oahm_slot_ram
// Slot store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module oahm_slot_ram import oahm_pkg::*; #(
	parameter int DEPTH     = CAPACITY_DEF,
	parameter int WIDTH     = 1 + KEY_BITS_DEF + VALUE_BITS_DEF,
	parameter int ADDR_BITS = $clog2(DEPTH)
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [ADDR_BITS-1:0] waddr,
	input  logic [WIDTH-1:0]     wdata,
	input  logic                 re,
	input  logic [ADDR_BITS-1:0] raddr,
	output logic [WIDTH-1:0]     rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/open_addressing_hash_map_top.sv */
// ----------------------------------------------------------------------------
// open_addressing_hash_map_top
// Key-to-value map with open addressing and linear probing, fixed capacity.
// ----------------------------------------------------------------------------
// After reset the block sweeps the slot memory once to clear every slot, with
// busy high. An item is transferred when start is high and busy is low. The
// item is registered, the product of the hash multiplier is registered, the
// home slot is read, then the slots are probed one after another through the
// single read port of the slot memory. The block takes no new item while one
// is in flight; the next item can be taken in the cycle the result is shown.
// The result is on found, read_value and table_full while done is high, which
// is for exactly one cycle; the receiver cannot stall it.
// ----------------------------------------------------------------------------
module open_addressing_hash_map_top import oahm_pkg::*; #(
	parameter int CAPACITY   = CAPACITY_DEF,
	parameter int KEY_BITS   = KEY_BITS_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic                  operation,
	input  logic [KEY_BITS-1:0]   lookup_key,
	input  logic [VALUE_BITS-1:0] write_value,
	output logic                  done,
	output logic                  found,
	output logic [VALUE_BITS-1:0] read_value,
	output logic                  table_full
);

	localparam int IDX_BITS = $clog2(CAPACITY);
	localparam int CNT_BITS = $clog2(CAPACITY + 1);
	localparam int LOAD_W   = CNT_BITS + 3;
	localparam int WORD     = 1 + KEY_BITS + VALUE_BITS;

	localparam logic [IDX_BITS-1:0] LAST_IDX   = IDX_BITS'(CAPACITY - 1);
	localparam logic [LOAD_W-1:0]   LOAD_LIMIT = LOAD_W'(CAPACITY * LOAD_DEN);

	typedef enum logic [4:0] {
		ST_CLEAR = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_HASH  = 5'b00100,
		ST_ADDR  = 5'b01000,
		ST_PROBE = 5'b10000
	} state_t;

	state_t state_q;

	logic                  op_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [IDX_BITS-1:0]   idx_q;
	logic [IDX_BITS-1:0]   idx_next;
	logic [CNT_BITS-1:0]   probe_cnt_q;
	logic [CNT_BITS-1:0]   count_q;
	logic                  done_q;
	logic                  found_q;
	logic [VALUE_BITS-1:0] rdval_q;
	logic                  full_q;

	logic [IDX_BITS-1:0]   home;
	logic                  ram_we;
	logic [IDX_BITS-1:0]   ram_waddr;
	logic [WORD-1:0]       ram_wdata;
	logic                  ram_re;
	logic [IDX_BITS-1:0]   ram_raddr;
	logic [WORD-1:0]       ram_rdata;

	logic                  rd_valid;
	logic [KEY_BITS-1:0]   rd_key;
	logic [VALUE_BITS-1:0] rd_val;
	logic                  hit;
	logic                  met;
	logic                  probe_last;
	logic [LOAD_W-1:0]     load_need;
	logic                  at_limit;
	logic                  is_set;
	logic                  claim;

	oahm_hash #(
		.CAPACITY (CAPACITY),
		.KEY_BITS (KEY_BITS),
		.IDX_BITS (IDX_BITS)
	) u_hash (
		.clk  (clk),
		.key  (key_q),
		.home (home)
	);

	oahm_slot_ram #(
		.DEPTH     (CAPACITY),
		.WIDTH     (WORD),
		.ADDR_BITS (IDX_BITS)
	) u_slot_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign rd_valid = ram_rdata[WORD-1];
	assign rd_key   = ram_rdata[KEY_BITS+VALUE_BITS-1:VALUE_BITS];
	assign rd_val   = ram_rdata[VALUE_BITS-1:0];

	assign hit        = rd_valid && (rd_key == key_q);
	assign met        = hit || !rd_valid;
	assign probe_last = (probe_cnt_q == CNT_BITS'(CAPACITY));
	assign idx_next   = (idx_q == LAST_IDX) ? '0 : idx_q + 1'b1;
	assign is_set     = (op_q == OP_SET);

	assign load_need = LOAD_W'(count_q) + LOAD_W'(1);
	assign at_limit  = (load_need * LOAD_W'(LOAD_NUM)) >= LOAD_LIMIT;

	// new key goes into the empty slot just read
	assign claim = is_set && !rd_valid && !at_limit;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = {1'b1, key_q, val_q};
		ram_re    = 1'b0;
		ram_raddr = home;
		case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_wdata = '0;
			end
			ST_ADDR: begin
				ram_re = 1'b1;
			end
			ST_PROBE: begin
				if (met) begin
					ram_we = is_set && (hit || !at_limit);
				end else if (!probe_last) begin
					ram_re    = 1'b1;
					ram_raddr = idx_next;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			idx_q       <= '0;
			probe_cnt_q <= '0;
			count_q     <= '0;
			done_q      <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					idx_q <= idx_next;
					if (idx_q == LAST_IDX) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_HASH;
					end
				end
				ST_HASH: begin
					state_q <= ST_ADDR;
				end
				ST_ADDR: begin
					idx_q       <= home;
					probe_cnt_q <= CNT_BITS'(1);
					state_q     <= ST_PROBE;
				end
				ST_PROBE: begin
					if (met || probe_last) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
						if (claim) begin
							count_q <= count_q + 1'b1;
						end
					end else begin
						idx_q       <= idx_next;
						probe_cnt_q <= probe_cnt_q + 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// item and result payload
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			op_q  <= operation;
			key_q <= lookup_key;
			val_q <= write_value;
		end
		if (state_q == ST_PROBE && (met || probe_last)) begin
			found_q <= hit;
			rdval_q <= hit ? rd_val : '0;
			full_q  <= is_set && !hit && (!met || at_limit);
		end
	end

	assign busy       = (state_q != ST_IDLE);
	assign done       = done_q;
	assign found      = found_q;
	assign read_value = rdval_q;
	assign table_full = full_q;

endmodule

/* rtl/oahm_checker.sv */
// ----------------------------------------------------------------------------
// oahm_checker
// Port-level checks on the hash map top level, bound to every instance.
// ----------------------------------------------------------------------------
module oahm_checker import oahm_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  start,
	input logic                  busy,
	input logic                  done,
	input logic                  found,
	input logic [VALUE_BITS-1:0] read_value,
	input logic                  table_full
);

	// a refused set never reports an existing key
	a_full_not_found: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(found && table_full))
		else $error("table_full and found together");

	// misses and refusals return zero
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !found |-> read_value == '0)
		else $error("nonzero read_value without a hit");

	// result comes as the item completes
	a_done_ends_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy && $past(busy))
		else $error("done without a completing item");

	// no result before the hash and the first probe are done after a transfer
	a_min_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy && !done ##1 !done ##1 !done)
		else $error("result too early after transfer");

endmodule

bind open_addressing_hash_map_top oahm_checker #(
	.VALUE_BITS (VALUE_BITS)
) u_oahm_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.done       (done),
	.found      (found),
	.read_value (read_value),
	.table_full (table_full)
);
